// ===== rtl/fdr_pkg.sv =====
package fdr_pkg;

    localparam int ETA_W    = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [15:0] ONE_Q15 = 16'h8000;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ETA_INCIDENT    = 8'd0,
        REG_ETA_TRANSMITTED = 8'd1
    } t_reg_index;

endpackage

// ===== rtl/fresnel_dielectric_reflectance_unit.sv =====
// Unpolarized Fresnel reflectance of a dielectric boundary.
// Input channel: i_valid / o_stall with i_cos_incident (signed Q1.15). A
// transaction is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_reflectance (Q1.15, 32768 = 1.0)
// and o_total_reflection. A transaction completes when o_valid is high and
// i_stall low.
// Configuration: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
// eta_incident (0) or eta_transmitted (1), both unsigned Q4.12; other indexes
// are ignored. Write only while the pipeline is empty.
// One item enters per cycle unless the receiver stalls. The depth is set by
// two 16-stage square-root pipelines and two 15- and 16-stage long-division
// pipelines in series (a third runs in parallel), one result bit per stage.
// Reset clears every stage valid and loads the index registers with 2048 and
// 410. When the receiver stalls with a result waiting, the whole pipeline
// holds and o_stall rises, so nothing is dropped or repeated.
module fresnel_dielectric_reflectance_unit
    import fdr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [15:0]   i_cos_incident,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [15:0]          o_reflectance,
    output logic                 o_total_reflection,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [ETA_W-1:0] r_eta_i;
    logic [ETA_W-1:0] r_eta_t;
    logic             w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_i <= 16'd2048;
            r_eta_t <= 16'd410;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_ETA_INCIDENT) begin
                r_eta_i <= i_cfg_data;
            end else if (i_cfg_index == REG_ETA_TRANSMITTED) begin
                r_eta_t <= i_cfg_data;
            end
        end
    end

    logic r_out_valid;
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: fold the sign, swap on exit, radicand 1 - c^2
    logic [15:0] w_raw;
    logic        n_s1_swap;
    logic [15:0] n_s1_c;
    logic [31:0] w_csq;
    logic        r_s1_valid;
    logic        r_s1_swap;
    logic [15:0] r_s1_c;
    logic [31:0] r_s1_rad;

    assign w_raw     = i_cos_incident;
    assign n_s1_swap = (w_raw == 16'd0) || w_raw[15];
    assign n_s1_c    = n_s1_swap ? (16'd0 - w_raw) : w_raw;
    assign w_csq     = n_s1_c * n_s1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_swap <= n_s1_swap;
            r_s1_c    <= n_s1_c;
            r_s1_rad  <= ONE_Q30 - w_csq;
        end
    end

    logic        w_q1_valid;
    logic [15:0] w_sin_i;
    logic [16:0] w_q1_side;

    fdr_isqrt_pipe #(.IN_W(32), .SIDE_W(17)) u_sqrt_sin (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s1_valid),
        .i_radicand (r_s1_rad),
        .i_side     ({r_s1_swap, r_s1_c}),
        .o_valid    (w_q1_valid),
        .o_root     (w_sin_i),
        .o_side     (w_q1_side)
    );

    // stage 2: ei * sin_i
    logic [15:0] w_ei_a;
    logic [15:0] w_et_a;
    logic        r_s2_valid;
    logic        r_s2_swap;
    logic [15:0] r_s2_c;
    logic [31:0] r_s2_p;
    logic [15:0] r_s2_et;

    assign w_ei_a = w_q1_side[16] ? r_eta_t : r_eta_i;
    assign w_et_a = w_q1_side[16] ? r_eta_i : r_eta_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= w_q1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_swap <= w_q1_side[16];
            r_s2_c    <= w_q1_side[15:0];
            r_s2_p    <= w_ei_a * w_sin_i;
            r_s2_et   <= w_et_a;
        end
    end

    // stage 3: exact total reflection test, set up the division
    logic        r_s3_valid;
    logic        r_s3_swap;
    logic [15:0] r_s3_c;
    logic        r_s3_tir;
    logic [15:0] r_s3_rem;
    logic [14:0] r_s3_low;
    logic [15:0] r_s3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_swap <= r_s2_swap;
            r_s3_c    <= r_s2_c;
            r_s3_tir  <= r_s2_p >= {1'b0, r_s2_et, 15'd0};
            r_s3_rem  <= r_s2_p[30:15];
            r_s3_low  <= r_s2_p[14:0];
            r_s3_den  <= r_s2_et;
        end
    end

    logic        w_d1_valid;
    logic [14:0] w_sin_t;
    logic [17:0] w_d1_side;

    fdr_div_pipe #(.DEN_W(16), .STEPS(15), .SIDE_W(18)) u_div_sin (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s3_valid),
        .i_rem_init (r_s3_rem),
        .i_low      (r_s3_low),
        .i_den      (r_s3_den),
        .i_side     ({r_s3_tir, r_s3_swap, r_s3_c}),
        .o_valid    (w_d1_valid),
        .o_quot     (w_sin_t),
        .o_side     (w_d1_side)
    );

    // stage 4: radicand 1 - sin_t^2
    logic [29:0] w_stsq;
    logic        r_s4_valid;
    logic [17:0] r_s4_side;
    logic [31:0] r_s4_rad;

    assign w_stsq = w_sin_t * w_sin_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side <= w_d1_side;
            r_s4_rad  <= ONE_Q30 - {2'b00, w_stsq};
        end
    end

    logic        w_q2_valid;
    logic [15:0] w_cos_t;
    logic [17:0] w_q2_side;

    fdr_isqrt_pipe #(.IN_W(32), .SIDE_W(18)) u_sqrt_cos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s4_valid),
        .i_radicand (r_s4_rad),
        .i_side     (r_s4_side),
        .o_valid    (w_q2_valid),
        .o_root     (w_cos_t),
        .o_side     (w_q2_side)
    );

    // stage 5: the four products of the amplitude ratios
    logic [15:0] w_ei_b;
    logic [15:0] w_et_b;
    logic [15:0] w_c_b;
    logic        r_s5_valid;
    logic        r_s5_tir;
    logic [31:0] r_s5_pa_a;
    logic [31:0] r_s5_pa_b;
    logic [31:0] r_s5_pe_a;
    logic [31:0] r_s5_pe_b;

    assign w_ei_b = w_q2_side[16] ? r_eta_t : r_eta_i;
    assign w_et_b = w_q2_side[16] ? r_eta_i : r_eta_t;
    assign w_c_b  = w_q2_side[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= w_q2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_tir  <= w_q2_side[17];
            r_s5_pa_a <= w_et_b * w_c_b;
            r_s5_pa_b <= w_ei_b * w_cos_t;
            r_s5_pe_a <= w_ei_b * w_c_b;
            r_s5_pe_b <= w_et_b * w_cos_t;
        end
    end

    // stage 6: |a - b| and a + b
    logic        r_s6_valid;
    logic        r_s6_tir;
    logic [31:0] r_s6_pa_diff;
    logic [32:0] r_s6_pa_sum;
    logic [31:0] r_s6_pe_diff;
    logic [32:0] r_s6_pe_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_tir     <= r_s5_tir;
            r_s6_pa_diff <= (r_s5_pa_a >= r_s5_pa_b) ? (r_s5_pa_a - r_s5_pa_b)
                                                     : (r_s5_pa_b - r_s5_pa_a);
            r_s6_pa_sum  <= {1'b0, r_s5_pa_a} + {1'b0, r_s5_pa_b};
            r_s6_pe_diff <= (r_s5_pe_a >= r_s5_pe_b) ? (r_s5_pe_a - r_s5_pe_b)
                                                     : (r_s5_pe_b - r_s5_pe_a);
            r_s6_pe_sum  <= {1'b0, r_s5_pe_a} + {1'b0, r_s5_pe_b};
        end
    end

    // ratio = diff * 2^15 / sum, numerator split into high part and low bits
    logic        w_d2_valid;
    logic [15:0] w_rpa_q;
    logic [1:0]  w_d2_side;
    logic        w_d3_valid;
    logic [15:0] w_rpe_q;
    logic        w_d3_side;

    fdr_div_pipe #(.DEN_W(33), .STEPS(16), .SIDE_W(2)) u_div_para (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s6_valid),
        .i_rem_init ({2'b00, r_s6_pa_diff[31:1]}),
        .i_low      ({r_s6_pa_diff[0], 15'd0}),
        .i_den      (r_s6_pa_sum),
        .i_side     ({r_s6_tir, r_s6_pa_sum == 33'd0}),
        .o_valid    (w_d2_valid),
        .o_quot     (w_rpa_q),
        .o_side     (w_d2_side)
    );

    fdr_div_pipe #(.DEN_W(33), .STEPS(16), .SIDE_W(1)) u_div_perp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_s6_valid),
        .i_rem_init ({2'b00, r_s6_pe_diff[31:1]}),
        .i_low      ({r_s6_pe_diff[0], 15'd0}),
        .i_den      (r_s6_pe_sum),
        .i_side     (r_s6_pe_sum == 33'd0),
        .o_valid    (w_d3_valid),
        .o_quot     (w_rpe_q),
        .o_side     (w_d3_side)
    );

    // stage 7: square both ratios
    logic [15:0] w_rpa;
    logic [15:0] w_rpe;
    logic        r_s7_valid;
    logic        r_s7_tir;
    logic [31:0] r_s7_pa_sq;
    logic [31:0] r_s7_pe_sq;

    assign w_rpa = w_d2_side[0] ? ONE_Q15 : w_rpa_q;
    assign w_rpe = w_d3_side    ? ONE_Q15 : w_rpe_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s7_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_tir   <= w_d2_side[1];
            r_s7_pa_sq <= w_rpa * w_rpa;
            r_s7_pe_sq <= w_rpe * w_rpe;
        end
    end

    // output register: mean, saturate, override on total reflection
    logic [32:0] w_sq_sum;
    logic [15:0] n_refl;
    logic [15:0] r_out_refl;
    logic        r_out_tir;

    assign w_sq_sum = {1'b0, r_s7_pa_sq} + {1'b0, r_s7_pe_sq};

    always_comb begin
        if (r_s7_tir || (w_sq_sum[32:16] > {1'b0, ONE_Q15})) begin
            n_refl = ONE_Q15;
        end else begin
            n_refl = w_sq_sum[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s7_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_refl <= n_refl;
            r_out_tir  <= r_s7_tir;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_reflectance      = r_out_refl;
    assign o_total_reflection = r_out_tir;

    a_tir_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_reflection) |-> (o_reflectance == ONE_Q15))
        else $error("total reflection without full reflectance");

    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reflectance <= ONE_Q15))
        else $error("reflectance above 1.0");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled with no waiting result");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && (i_cfg_index == REG_ETA_INCIDENT))
            |=> (r_eta_i == $past(i_cfg_data)))
        else $error("eta_incident write lost");

    a_ratio_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_d3_valid == w_d2_valid)
        else $error("ratio dividers out of step");

endmodule

// ===== rtl/fdr_isqrt_pipe.sv =====
module fdr_isqrt_pipe #(
    parameter int IN_W   = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [IN_W-1:0]      i_radicand,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [IN_W/2-1:0]    o_root,
    output logic [SIDE_W-1:0]    o_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    logic              s_vld  [0:ROOT_W];
    logic [REM_W-1:0]  s_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] s_root [0:ROOT_W];
    logic [IN_W-1:0]   s_rad  [0:ROOT_W];
    logic [SIDE_W-1:0] s_side [0:ROOT_W];

    assign s_vld[0]  = i_valid;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = i_radicand;
    assign s_side[0] = i_side;

    // one result bit per stage, restoring digit recurrence
    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic              r_vld;
        logic [REM_W-1:0]  r_rem;
        logic [ROOT_W-1:0] r_root;
        logic [IN_W-1:0]   r_rad;
        logic [SIDE_W-1:0] r_side;
        logic [REM_W-1:0]  w_shift;
        logic [REM_W-1:0]  w_trial;
        logic              w_ge;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        assign w_shift = {s_rem[s][REM_W-3:0], s_rad[s][IN_W-1:IN_W-2]};
        assign w_trial = {s_root[s], 2'b01};
        assign w_ge    = w_shift >= w_trial;
        assign n_rem   = w_ge ? (w_shift - w_trial) : w_shift;
        assign n_root  = {s_root[s][ROOT_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_rad  <= {s_rad[s][IN_W-3:0], 2'b00};
                r_side <= s_side[s];
            end
        end

        assign s_vld[s+1]  = r_vld;
        assign s_rem[s+1]  = r_rem;
        assign s_root[s+1] = r_root;
        assign s_rad[s+1]  = r_rad;
        assign s_side[s+1] = r_side;
    end

    assign o_valid = s_vld[ROOT_W];
    assign o_root  = s_root[ROOT_W];
    assign o_side  = s_side[ROOT_W];

endmodule

// ===== rtl/fdr_div_pipe.sv =====
module fdr_div_pipe #(
    parameter int DEN_W  = 16,
    parameter int STEPS  = 16,
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DEN_W-1:0]     i_rem_init,
    input  logic [STEPS-1:0]     i_low,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [STEPS-1:0]     o_quot,
    output logic [SIDE_W-1:0]    o_side
);

    logic              s_vld  [0:STEPS];
    logic [DEN_W-1:0]  s_rem  [0:STEPS];
    logic [STEPS-1:0]  s_low  [0:STEPS];
    logic [STEPS-1:0]  s_quot [0:STEPS];
    logic [DEN_W-1:0]  s_den  [0:STEPS];
    logic [SIDE_W-1:0] s_side [0:STEPS];

    assign s_vld[0]  = i_valid;
    assign s_rem[0]  = i_rem_init;
    assign s_low[0]  = i_low;
    assign s_quot[0] = '0;
    assign s_den[0]  = i_den;
    assign s_side[0] = i_side;

    // shift in one numerator bit per stage, subtract when it fits
    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        logic              r_vld;
        logic [DEN_W-1:0]  r_rem;
        logic [STEPS-1:0]  r_low;
        logic [STEPS-1:0]  r_quot;
        logic [DEN_W-1:0]  r_den;
        logic [SIDE_W-1:0] r_side;
        logic [DEN_W:0]    w_shift;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;
        logic [DEN_W-1:0]  n_rem;

        assign w_shift = {s_rem[s], s_low[s][STEPS-1]};
        assign w_diff  = w_shift - {1'b0, s_den[s]};
        assign w_ge    = w_shift >= {1'b0, s_den[s]};
        assign n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_low  <= {s_low[s][STEPS-2:0], 1'b0};
                r_quot <= {s_quot[s][STEPS-2:0], w_ge};
                r_den  <= s_den[s];
                r_side <= s_side[s];
            end
        end

        assign s_vld[s+1]  = r_vld;
        assign s_rem[s+1]  = r_rem;
        assign s_low[s+1]  = r_low;
        assign s_quot[s+1] = r_quot;
        assign s_den[s+1]  = r_den;
        assign s_side[s+1] = r_side;
    end

    assign o_valid = s_vld[STEPS];
    assign o_quot  = s_quot[STEPS];
    assign o_side  = s_side[STEPS];

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fdr_pkg::*;

    typedef struct packed {
        logic [15:0] refl;
        logic        tir;
    } t_fresnel_result;

    class fresnel_scoreboard;
        logic [15:0]     eta_inc;
        logic [15:0]     eta_trn;
        t_fresnel_result pending[$];
        int              errors;
        int              checked;
        int              tir_seen;

        function new();
            eta_inc = 16'd2048;
            eta_trn = 16'd410;
            errors = 0;
            checked = 0;
            tir_seen = 0;
        endfunction

        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function logic [63:0] ratio(logic [63:0] a, logic [63:0] b);
            logic [63:0] d;
            d = (a >= b) ? a - b : b - a;
            if (a + b == 0) return 64'd32768;
            return (d << 15) / (a + b);
        endfunction

        function void write_reg(t_reg_index idx, logic [15:0] val);
            if (idx == REG_ETA_INCIDENT) eta_inc = val;
            else if (idx == REG_ETA_TRANSMITTED) eta_trn = val;
        endfunction

        function void note_input(logic [15:0] raw);
            logic [63:0] ei, et, c, si, st, ct, rpa, rpe, r;
            t_fresnel_result e;
            ei = eta_inc;
            et = eta_trn;
            if (raw != 0 && raw < 16'h8000) begin
                c = raw;
            end else begin
                ei = eta_trn;
                et = eta_inc;
                c = (raw == 0) ? 0 : 64'h10000 - raw;
            end
            si = isqrt(64'h4000_0000 - c * c);
            if (ei * si >= 64'd32768 * et) begin
                e.refl = ONE_Q15;
                e.tir = 1'b1;
            end else begin
                st = (ei * si) / et;
                ct = isqrt(64'h4000_0000 - st * st);
                rpa = ratio(et * c, ei * ct);
                rpe = ratio(ei * c, et * ct);
                r = (rpa * rpa + rpe * rpe) >> 16;
                if (r > 64'd32768) r = 64'd32768;
                e.refl = r[15:0];
                e.tir = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [15:0] refl, logic tir);
            t_fresnel_result e;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result refl=%0d tir=%0b", $time, refl, tir);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (tir) tir_seen++;
            if (refl !== e.refl) begin
                $display("%0t: reflectance expected %0d actual %0d", $time, e.refl, refl);
                errors++;
            end
            if (tir !== e.tir) begin
                $display("%0t: total_reflection expected %0b actual %0b",
                         $time, e.tir, tir);
                errors++;
            end
        endfunction
    endclass

    localparam int LATENCY = 71;
    localparam int LIMIT = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [15:0]   cos_in;
    logic                 out_valid;
    logic                 out_stall;
    logic [15:0]          refl_out;
    logic                 tir_out;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    fresnel_scoreboard sb;
    int  cycles;
    int  sent;
    bit  hold_off;
    bit  done;

    fresnel_dielectric_reflectance_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_stall(in_stall),
        .i_cos_incident(cos_in),
        .o_valid(out_valid),
        .i_stall(out_stall),
        .o_reflectance(refl_out),
        .o_total_reflection(tir_out),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function int gap_len();
        int p;
        p = int'($urandom_range(0, 99));
        if (p < 50) return 0;
        if (p < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // keep valid high across back-to-back transactions, drop it only for a gap
    task automatic send_cos(logic [15:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        cos_in <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(v);
        sent++;
    endtask

    task automatic write_cfg(t_reg_index idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // random cosine: bias toward the ends, grazing angles and zero
    function logic [15:0] pick_cos();
        int p;
        p = int'($urandom_range(0, 9));
        if (p == 0) return 16'($urandom_range(0, 40));
        if (p == 1) return 16'(32'h10000 - $urandom_range(1, 40));
        if (p == 2) return 16'(32'h8000 + $urandom_range(0, 40));
        if (p == 3) return 16'(32'h7FFF - $urandom_range(0, 40));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic run_phase(logic [15:0] ei, logic [15:0] et, int n);
        write_cfg(REG_ETA_INCIDENT, ei);
        write_cfg(REG_ETA_TRANSMITTED, et);
        repeat (n) send_cos(pick_cos());
        drain();
    endtask

    // receiver: random stalls, with one long hold-off
    always @(posedge clk) begin
        int g;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_off) begin
            out_stall <= 1'b1;
        end else begin
            g = $urandom_range(0, 99);
            out_stall <= (g < 25);
        end
        if (rst_n && out_valid && !out_stall) sb.check_result(refl_out, tir_out);
    end

    initial begin
        hold_off = 1'b0;
        repeat (300) @(posedge clk);
        while (sent < 100) @(posedge clk);
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT && !done) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        sent = 0;
        done = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cos_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset indices first
        send_cos(16'h0000);
        send_cos(16'h0001);
        send_cos(16'h7FFF);
        send_cos(16'h8000);
        send_cos(16'hFFFF);
        send_cos(16'h4000);
        send_cos(16'hC000);
        send_cos(16'h5555);
        send_cos(16'hAAAA);
        drain();
        write_cfg(REG_ETA_INCIDENT, 16'hFFFF);
        write_cfg(REG_ETA_TRANSMITTED, 16'h0001);
        send_cos(16'h7FFF);
        send_cos(16'h8000);
        send_cos(16'h0001);
        send_cos(16'h0000);
        drain();
        write_cfg(REG_ETA_INCIDENT, 16'h0001);
        write_cfg(REG_ETA_TRANSMITTED, 16'hFFFF);
        send_cos(16'h7FFF);
        send_cos(16'h8000);
        send_cos(16'h2AAA);
        send_cos(16'hD556);
        drain();
        // equal indices: no reflection
        write_cfg(REG_ETA_INCIDENT, 16'd6144);
        write_cfg(REG_ETA_TRANSMITTED, 16'd6144);
        send_cos(16'h6000);
        send_cos(16'hA000);
        drain();

        run_phase(16'd4096, 16'd6144, 150);
        run_phase(16'd6144, 16'd4096, 150);
        run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 100);
        run_phase(16'd2048, 16'd410, 100);

        done = 1'b1;
        $display("inputs %0d, results checked %0d, total reflections %0d",
                 sent, sb.checked, sb.tir_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
